// ===== hdl/jep_pkg.sv =====
`default_nettype none

package jep_pkg;

  // field widths fixed by the request and result formats
  localparam int NUM_W  = 7;   // ring_size, start_pos, person
  localparam int STEP_W = 16;  // step

  // restoring remainder: one dividend bit per cycle
  localparam int DIV_STEPS = STEP_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] dividend;
    logic [NUM_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] rem;
  } mod_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/jep_ram.sv =====
`default_nettype none

module jep_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/jep_mod.sv =====
`default_nettype none

// Bit-serial restoring remainder: dividend mod divisor, one bit per cycle.
module jep_mod (
  input  wire               clk,
  input  wire               rst,
  input  jep_pkg::mod_req_t req,
  output jep_pkg::mod_rsp_t rsp
);

  logic [jep_pkg::STEP_W-1:0] quo;
  logic [jep_pkg::NUM_W:0]    rem;
  logic [jep_pkg::NUM_W-1:0]  div;
  logic [jep_pkg::DCNT_W-1:0] cnt;
  logic                       busy;
  logic                       done;

  logic [jep_pkg::NUM_W:0] shifted;
  logic [jep_pkg::NUM_W:0] div_ext;

  assign shifted = {rem[jep_pkg::NUM_W-1:0], quo[jep_pkg::STEP_W-1]};
  assign div_ext = {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == jep_pkg::DCNT_W'(jep_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      div <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[jep_pkg::STEP_W-2:0], 1'b0};
      if (shifted >= div_ext) begin
        rem <= shifted - div_ext;
      end else begin
        rem <= shifted;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem[jep_pkg::NUM_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/josephus_elimination_order.sv =====
`default_nettype none

// Channel  Dir  Signals                     Content
// s_axis   in   tvalid/tready/tdata[31:0]   one request: ring_size, start_pos, step
// m_axis   out  tvalid/tready/tdata[7:0]    one eliminated person per transfer,
//               tlast, tuser                tlast on the run's final one, tuser = bad_request
//
// Sequence: a request first builds the successor ring, then for each of the n
//   rounds works out (step-1) mod r in the serial remainder unit, takes that
//   many hops through the one-port-read table RAM, then reads the victim,
//   unlinks it and hands the result to the output register.
//   A rejected request goes straight to the output hand-off.
// Reset: rst clears the sequencer and the output valid; the table RAM is not
//   cleared, every entry a request reads is written first by that request.
// Stalls: s_axis_tready is high only while no request is in progress; a held
//   output stalls the walk only when the next result is ready to go out.
module josephus_elimination_order #(
  parameter int MAX_PEOPLE = 64
) (
  input  wire         clk,
  input  wire         rst,
  // tdata: ring_size [6:0], start_pos [13:7], step [29:14], zero [31:30]
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,
  // tdata: person [6:0], zero [7]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  // tuser: bad_request [0]
  output logic        m_axis_tuser
);

  localparam int IDX_W = $clog2(MAX_PEOPLE);
  localparam int NUM_W = jep_pkg::NUM_W;
  localparam int STEP_W = jep_pkg::STEP_W;
  localparam logic [NUM_W-1:0] ONE_N = NUM_W'(1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;  // write ring successors
  localparam logic [2:0] ST_MOD   = 3'd2;  // wait for hop count
  localparam logic [2:0] ST_HREAD = 3'd3;  // issue hop read
  localparam logic [2:0] ST_HWAIT = 3'd4;  // take hop data
  localparam logic [2:0] ST_VREAD = 3'd5;  // read victim index
  localparam logic [2:0] ST_VWAIT = 3'd6;  // victim in, read its successor
  localparam logic [2:0] ST_LINK  = 3'd7;  // unlink victim, then output

  logic [2:0] state;
  logic       emit_pend;  // result waiting for the output register

  // request fields
  logic [NUM_W-1:0]  in_n;
  logic [NUM_W-1:0]  in_s;
  logic [STEP_W-1:0] in_m;
  logic              in_bad;

  assign in_n = s_axis_tdata[6:0];
  assign in_s = s_axis_tdata[13:7];
  assign in_m = s_axis_tdata[29:14];
  assign in_bad = (in_n == '0) || (in_s == '0) || (in_m == '0) || (in_s > in_n)
               || (in_n > NUM_W'(MAX_PEOPLE));

  logic [NUM_W-1:0]  n_reg;
  logic [NUM_W-1:0]  s_reg;
  logic [STEP_W-1:0] m_reg;
  logic              bad;
  logic [NUM_W-1:0]  rounds;      // people still in the ring
  logic [NUM_W-1:0]  emitted;
  logic [NUM_W-1:0]  hop_left;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  cursor;
  logic [IDX_W-1:0]  victim;

  logic [IDX_W:0]    idx_inc;
  logic [NUM_W-1:0]  idx_ext;
  logic              init_done;
  logic [NUM_W-1:0]  cursor_init;
  logic              out_free;
  logic              final_round;

  assign idx_inc     = {1'b0, idx} + 1'b1;
  assign idx_ext     = {{(NUM_W-IDX_W){1'b0}}, idx};
  assign init_done   = (idx_ext == n_reg - ONE_N);
  assign cursor_init = (s_reg == ONE_N) ? n_reg - ONE_N : s_reg - NUM_W'(2);
  assign out_free    = !m_axis_tvalid || m_axis_tready;
  assign final_round = bad || (rounds == ONE_N);

  // successor table
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cursor;
    ram_wdata = ram_rdata;
    ram_raddr = cursor;
    case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = init_done ? '0 : idx_inc[IDX_W-1:0];
      end
      ST_VWAIT: begin
        ram_raddr = ram_rdata;  // successor of the victim
      end
      ST_LINK: begin
        ram_we    = !bad;       // cursor now skips the victim
        ram_raddr = victim;     // keep the victim's successor while output waits
      end
      default: begin
      end
    endcase
  end

  jep_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_PEOPLE)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // hop count = (step - 1) mod remaining
  jep_pkg::mod_req_t mod_req;
  jep_pkg::mod_rsp_t mod_rsp;

  always_comb begin
    mod_req.dividend = m_reg - 1'b1;
    mod_req.divisor  = (state == ST_INIT) ? n_reg : rounds - ONE_N;
    mod_req.start    = ((state == ST_INIT) && init_done)
                    || ((state == ST_LINK) && emit_pend && out_free && !final_round);
  end

  jep_mod u_mod (
    .clk(clk),
    .rst(rst),
    .req(mod_req),
    .rsp(mod_rsp)
  );

  assign s_axis_tready = (state == ST_IDLE) && !emit_pend;

  // sequencer; LINK doubles as the output hand-off state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      emit_pend <= 1'b0;
      emitted   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            emitted <= '0;
            if (in_bad) begin
              emit_pend <= 1'b1;
              state     <= ST_LINK;
            end else begin
              state <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          if (init_done) begin
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (mod_rsp.done) begin
            state <= (mod_rsp.rem == '0) ? ST_VREAD : ST_HREAD;
          end
        end
        ST_HREAD: begin
          state <= ST_HWAIT;
        end
        ST_HWAIT: begin
          state <= (hop_left == ONE_N) ? ST_VREAD : ST_HREAD;
        end
        ST_VREAD: begin
          state <= ST_VWAIT;
        end
        ST_VWAIT: begin
          emit_pend <= 1'b1;
          state     <= ST_LINK;
        end
        ST_LINK: begin
          if (out_free) begin
            emit_pend <= 1'b0;
            emitted   <= emitted + ONE_N;
            state     <= final_round ? ST_IDLE : ST_MOD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n_reg  <= in_n;
        s_reg  <= in_s;
        m_reg  <= in_m;
        bad    <= in_bad;
        idx    <= '0;
        rounds <= in_n;
      end
      ST_INIT: begin
        idx <= idx_inc[IDX_W-1:0];
        if (init_done) begin
          cursor <= cursor_init[IDX_W-1:0];
        end
      end
      ST_MOD: begin
        hop_left <= mod_rsp.rem;
      end
      ST_HWAIT: begin
        cursor   <= ram_rdata;
        hop_left <= hop_left - ONE_N;
      end
      ST_VWAIT: begin
        victim <= ram_rdata;
      end
      ST_LINK: begin
        if (emit_pend && out_free) begin
          rounds <= rounds - ONE_N;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_LINK) && emit_pend && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_LINK) && emit_pend && out_free) begin
      m_axis_tdata <= {1'b0, bad ? {NUM_W{1'b0}}
                                 : ({{(NUM_W-IDX_W){1'b0}}, victim} + ONE_N)};
      m_axis_tlast <= final_round;
      m_axis_tuser <= bad;
    end
  end

`ifndef SYNTHESIS
  // a good run hands off its last result after exactly n-1 earlier ones
  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_LINK) && emit_pend && out_free && final_round && !bad)
      |-> (emitted == n_reg - ONE_N))
    else $error("run ended with wrong result count");

  // hop counts only arrive while the sequencer waits for them
  assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> (state == ST_MOD))
    else $error("remainder done outside wait state");

  // hop count stays below the ring's population
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD && mod_rsp.done) |-> (mod_rsp.rem < rounds))
    else $error("hop count not below remaining people");

  // a hop is only taken with hops left
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_HWAIT) |-> (hop_left != '0))
    else $error("hop taken with none left");
`endif

endmodule

`default_nettype wire

// ===== verif/josephus_elimination_order_tb.sv =====
`default_nettype none

module josephus_elimination_order_tb;

  localparam int NUM_W = jep_pkg::NUM_W;
  localparam int STEP_W = jep_pkg::STEP_W;
  localparam int MAX_PEOPLE = 64;
  localparam int RECEIVER_HOLD = 3000;
  // slowest legal run: every request a full 64 ring, every removal behind the
  // longest receiver stall, every request behind the longest sender gap
  localparam longint CYCLE_LIMIT = 6_000_000;
  localparam int ERROR_PRINTS = 30;

  typedef struct {
    bit [NUM_W-1:0] person;
    bit             last;
    bit             bad;
  } removal_t;

  class elimination_checker;
    bit [5:0]  ring_next [MAX_PEOPLE];
    bit [5:0]  walk_pos;
    bit [15:0] hops;
    removal_t  due_removals[$];
    int        mismatches;
    int        removals_seen;
    int        rejected;

    // works out the whole elimination order of one accepted request
    function void note_request(bit [NUM_W-1:0] n, bit [NUM_W-1:0] s,
                               bit [STEP_W-1:0] m);
      removal_t item;
      int       victim;
      if (n == 0 || s == 0 || m == 0 || s > n || n > MAX_PEOPLE) begin
        item.person = '0;
        item.last   = 1'b1;
        item.bad    = 1'b1;
        due_removals.push_back(item);
        rejected++;
        return;
      end
      for (int i = 0; i < n; i++) ring_next[i] = 6'((i + 1) % n);
      // start from the one sitting just before person s
      walk_pos = (s == 1) ? 6'(n - 1) : 6'(s - 2);
      for (int r = n; r > 0; r--) begin
        hops = 16'((int'(m) - 1) % r);
        for (int h = 0; h < hops; h++) walk_pos = ring_next[walk_pos];
        victim = ring_next[walk_pos];
        ring_next[walk_pos] = ring_next[victim];
        item.person = NUM_W'(victim + 1);
        item.last   = (r == 1);
        item.bad    = 1'b0;
        due_removals.push_back(item);
      end
    endfunction

    function void check_result(bit [NUM_W-1:0] person, bit last, bit bad);
      removal_t want;
      removals_seen++;
      if (due_removals.size() == 0) begin
        mismatches++;
        if (mismatches <= ERROR_PRINTS)
          $error("unexpected result: person %0d last %0d bad_request %0d",
                 person, last, bad);
        return;
      end
      want = due_removals.pop_front();
      if (person != want.person) begin
        mismatches++;
        if (mismatches <= ERROR_PRINTS)
          $error("person: expected %0d, actual %0d", want.person, person);
      end
      if (last != want.last) begin
        mismatches++;
        if (mismatches <= ERROR_PRINTS)
          $error("last: expected %0d, actual %0d", want.last, last);
      end
      if (bad != want.bad) begin
        mismatches++;
        if (mismatches <= ERROR_PRINTS)
          $error("bad_request: expected %0d, actual %0d", want.bad, bad);
      end
    endfunction

    function int pending();
      return due_removals.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  elimination_checker order_check = new();

  bit     no_idle = 1'b0;
  logic   hold_off = 1'b0;
  int     requests_sent = 0;
  int     random_sent = 0;
  int     biggest_ring = 0;
  longint cycles = 0;

  josephus_elimination_order #(.MAX_PEOPLE(MAX_PEOPLE)) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one, none in quiet stretches
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // one request; valid stays up into the next call when there is no gap
  task automatic send_request(input bit [NUM_W-1:0] n, input bit [NUM_W-1:0] s,
                              input bit [STEP_W-1:0] m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {2'b00, m, s, n};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    order_check.note_request(n, s, m);
    requests_sent++;
    if (n <= MAX_PEOPLE && s <= n && s != 0 && m != 0 && n > biggest_ring)
      biggest_ring = n;
  endtask

  // result side: sample transfer on the edge, then pick the next ready
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        order_check.check_result(m_axis_tdata[NUM_W-1:0], m_axis_tlast, m_axis_tuser);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // long receiver hold once the random part is underway: output backs up
  // and the request side stalls while items keep being offered
  initial begin
    wait (random_sent >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (RECEIVER_HOLD) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, order_check.pending());
        $display("josephus_elimination_order_tb failed");
        $finish;
      end
    end
  end

  initial begin
    bit [NUM_W-1:0]  n, s;
    bit [STEP_W-1:0] m;
    int              roll;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, step of one, rejects of every kind
    send_request(7'd1,   7'd1,   16'd1);
    send_request(7'd1,   7'd1,   16'hFFFF);
    send_request(7'd2,   7'd2,   16'd2);
    send_request(7'd7,   7'd3,   16'd3);
    send_request(7'd10,  7'd10,  16'd1);
    send_request(7'd64,  7'd1,   16'd1);
    send_request(7'd64,  7'd64,  16'hFFFF);
    send_request(7'd64,  7'd33,  16'd2);
    send_request(7'd64,  7'd17,  16'd64);
    send_request(7'd41,  7'd1,   16'h8000);
    send_request(7'd13,  7'd5,   16'd13);
    send_request(7'd0,   7'd1,   16'd1);      // zero ring size
    send_request(7'd5,   7'd0,   16'd3);      // zero start
    send_request(7'd5,   7'd2,   16'd0);      // zero step
    send_request(7'd0,   7'd0,   16'd0);
    send_request(7'd5,   7'd6,   16'd3);      // start past the ring
    send_request(7'd63,  7'd64,  16'd1);
    send_request(7'd65,  7'd1,   16'd1);      // ring too large
    send_request(7'd127, 7'd127, 16'hFFFF);
    send_request(7'd100, 7'd50,  16'd7);
    send_request(7'd3,   7'd3,   16'd5);
    send_request(7'd1,   7'd2,   16'd1);

    // random: mostly valid rings, small ones most often, some noise
    for (int k = 0; k < 118; k++) begin
      if (k % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        roll = $urandom_range(0, 99);
        if (roll < 80)      n = NUM_W'($urandom_range(1, 12));
        else if (roll < 95) n = NUM_W'($urandom_range(13, 40));
        else                n = NUM_W'($urandom_range(41, 64));
        s = NUM_W'($urandom_range(1, n));
        roll = $urandom_range(0, 9);
        if (roll < 4)      m = STEP_W'($urandom_range(1, 8));
        else if (roll < 7) m = STEP_W'($urandom_range(1, 300));
        else               m = STEP_W'($urandom_range(1, 65535));
      end else begin
        n = NUM_W'($urandom_range(0, 127));
        s = NUM_W'($urandom_range(0, 127));
        m = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom());
      end
      send_request(n, s, m);
      random_sent++;
    end
    no_idle = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (order_check.pending() != 0 || hold_off) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("%0d requests (%0d rejected), %0d removals checked, rings up to %0d",
             requests_sent, order_check.rejected, order_check.removals_seen,
             biggest_ring);
    $display("output held off %0d cycles once; %0d mismatches, %0d outstanding",
             RECEIVER_HOLD, order_check.mismatches, order_check.pending());
    if (order_check.mismatches == 0 && order_check.pending() == 0) begin
      $display("josephus_elimination_order_tb passed");
    end else begin
      $display("josephus_elimination_order_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/jep_pkg.sv
hdl/jep_ram.sv
hdl/jep_mod.sv
hdl/josephus_elimination_order.sv
verif/josephus_elimination_order_tb.sv
